>>> src/bounding_sphere_ritter_defines.svh
// ----------------------------------------------------------------------------
// bounding_sphere_ritter_defines
// assertion macros shared by the bounding sphere block
// ----------------------------------------------------------------------------
`ifndef BOUNDING_SPHERE_RITTER_DEFINES_SVH
`define BOUNDING_SPHERE_RITTER_DEFINES_SVH
`ifndef SYNTHESIS
`define RBS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define RBS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define RBS_ASSERT_IMP(label, ante, cons)
`define RBS_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> src/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// shared constants, control struct and solver states of the bounding sphere
// ----------------------------------------------------------------------------
`default_nettype none
package rbs_pkg;
	localparam int RBS_MAX_POINTS = 128;
	localparam int RBS_COORD_BITS = 16;
	localparam int RBS_FRAC_BITS  = 30;
	localparam int RBS_QDEPTH     = 2;

	typedef struct packed {
		logic store;
		logic last;
		logic drop;
	} rbs_ctl_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_AXDIFF,
		B_SUM,
		B_AXCMP,
		B_INIT,
		B_SQRT,
		B_SQDONE,
		B_RR1,
		B_RR2,
		B_RD,
		B_PTDIFF,
		B_PTCMP,
		B_DIV,
		B_MOVE,
		B_RUPD,
		B_OUT
	} rbs_state_t;
endpackage
`default_nettype wire

>>> src/rbs_front.sv
// ----------------------------------------------------------------------------
// rbs_front
// takes points, counts them and tracks the extreme points of each axis
// ----------------------------------------------------------------------------
`default_nettype none
module rbs_front #(
	parameter int MAX_POINTS = rbs_pkg::RBS_MAX_POINTS,
	parameter int COORD_BITS = rbs_pkg::RBS_COORD_BITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    accept,
	input  wire logic signed [COORD_BITS-1:0]            x,
	input  wire logic signed [COORD_BITS-1:0]            y,
	input  wire logic signed [COORD_BITS-1:0]            z,
	input  wire logic                                    last,
	output rbs_pkg::rbs_ctl_t                            ctl,
	output logic [21*COORD_BITS+$clog2(MAX_POINTS)-1:0]  data
);
	localparam int CB   = COORD_BITS;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int IW   = $clog2(MAX_POINTS);

	logic [CNTW-1:0]        cnt_q;
	logic                   drop_q;
	logic signed [CB-1:0]   minp_q [3][3];
	logic signed [CB-1:0]   maxp_q [3][3];
	logic signed [CB-1:0]   minp_n [3][3];
	logic signed [CB-1:0]   maxp_n [3][3];
	logic signed [CB-1:0]   pt [3];
	logic                   store;
	logic                   first;

	always_comb begin
		pt[0] = x;
		pt[1] = y;
		pt[2] = z;
		store = (cnt_q != CNTW'(MAX_POINTS));
		first = (cnt_q == '0);
		for (int a = 0; a < 3; a++) begin
			for (int c = 0; c < 3; c++) begin
				minp_n[a][c] = minp_q[a][c];
				maxp_n[a][c] = maxp_q[a][c];
			end
			// strict compares keep the first extreme point
			if (store && (first || pt[a] < minp_q[a][a])) begin
				for (int c = 0; c < 3; c++) minp_n[a][c] = pt[c];
			end
			if (store && (first || pt[a] > maxp_q[a][a])) begin
				for (int c = 0; c < 3; c++) maxp_n[a][c] = pt[c];
			end
		end
	end

	always_comb begin
		ctl.store = store;
		ctl.last  = last;
		ctl.drop  = drop_q | ~store;
		for (int c = 0; c < 3; c++) data[c*CB +: CB] = pt[c];
		for (int a = 0; a < 3; a++) begin
			for (int c = 0; c < 3; c++) begin
				data[(3+3*a+c)*CB +: CB]  = minp_n[a][c];
				data[(12+3*a+c)*CB +: CB] = maxp_n[a][c];
			end
		end
		data[21*CB +: IW] = cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else if (store) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			minp_q <= minp_n;
			maxp_q <= maxp_n;
		end
	end
endmodule
`default_nettype wire

>>> src/rbs_queue.sv
// ----------------------------------------------------------------------------
// rbs_queue
// short queue between the point front and the sphere solver
// ----------------------------------------------------------------------------
`default_nettype none
module rbs_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int DEPTH = rbs_pkg::RBS_QDEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PW'(1);
			if (pop)  rd_q <= rd_q + PW'(1);
			if (push && !pop)      cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

>>> src/rbs_back.sv
// ----------------------------------------------------------------------------
// rbs_back
// point store and sequential solver: start sphere and growth pass
// ----------------------------------------------------------------------------
`default_nettype none
module rbs_back #(
	parameter int MAX_POINTS = rbs_pkg::RBS_MAX_POINTS,
	parameter int COORD_BITS = rbs_pkg::RBS_COORD_BITS
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          q_empty,
	output logic                                               q_pop,
	input  wire rbs_pkg::rbs_ctl_t                             q_ctl,
	input  wire logic [21*COORD_BITS+$clog2(MAX_POINTS)-1:0]   q_data,
	input  wire logic                                          pop,
	output logic                                               empty,
	output logic signed [COORD_BITS-1:0]                       center_x,
	output logic signed [COORD_BITS-1:0]                       center_y,
	output logic signed [COORD_BITS-1:0]                       center_z,
	output logic [COORD_BITS-1:0]                              radius,
	output logic                                               overflowed
);
	localparam int CB   = COORD_BITS;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int IW   = $clog2(MAX_POINTS);
	localparam int ACCW = 2*CB + 4;
	localparam int D2W  = (ACCW > 64) ? 64 : ACCW;
	localparam int SQH  = D2W / 2;
	localparam int SQW  = SQH + 1;
	localparam int RMW  = SQH + 2;
	localparam int FB   = rbs_pkg::RBS_FRAC_BITS;
	localparam int MBW  = (CB + 1 > FB) ? CB + 1 : FB;
	localparam int PW   = CB + 1 + MBW;
	localparam int SQC  = $clog2(SQH);
	localparam int DVC  = $clog2(FB);
	localparam logic [ACCW-1:0] D2_MAX = ACCW'({D2W{1'b1}});
	localparam logic [CB-1:0]   R_MAX  = {CB{1'b1}};

	rbs_pkg::rbs_state_t state_q, state_n;

	logic [3*CB-1:0]        mem [MAX_POINTS];
	logic [3*CB-1:0]        rdata_q;
	logic signed [CB-1:0]   minp_q [3][3];
	logic signed [CB-1:0]   maxp_q [3][3];
	logic [CNTW-1:0]        count_q;
	logic                   drop_q;
	logic [CNTW-1:0]        i_q;
	logic [1:0]             ax_q;
	logic [1:0]             bax_q;
	logic [1:0]             step_q;
	logic                   grow_q;
	logic signed [CB:0]     diff_q [3];
	logic [CB:0]            mag_d [3];
	logic [PW-1:0]          prod_q;
	logic [ACCW-1:0]        acc_q;
	logic [D2W-1:0]         acc_sat;
	logic [D2W-1:0]         best_q;
	logic signed [CB-1:0]   center_q [3];
	logic [CB-1:0]          r_q;
	logic [2*CB-1:0]        rr_q;
	logic [D2W-1:0]         sq_n_q;
	logic [RMW-1:0]         sq_rem_q;
	logic [SQH-1:0]         sq_root_q;
	logic [SQC-1:0]         sq_cnt_q;
	logic [SQW-1:0]         d_q;
	logic [SQW:0]           dv_rem_q;
	logic [DVC-1:0]         dv_cnt_q;
	logic [FB-1:0]          f_q;
	logic                   out_valid_q;
	logic signed [CB-1:0]   out_center_q [3];
	logic [CB-1:0]          out_radius_q;
	logic                   out_drop_q;

	logic [IW-1:0]          q_idx;
	logic [1:0]             sel;
	logic [CB:0]            mul_a;
	logic [MBW-1:0]         mul_b;
	logic [RMW-1:0]         rem_t;
	logic [RMW-1:0]         trial;
	logic [SQW-1:0]         root_ceil;
	logic [SQW:0]           half_t;
	logic [SQW:0]           grow_t;
	logic [SQW+1:0]         rem2;
	logic [SQW+1:0]         den;
	logic                   last_pt;
	logic                   outside;
	logic [1:0]             mv_k;
	logic signed [CB:0]     c_new;

	assign q_idx     = q_data[21*CB +: IW];
	assign acc_sat   = (acc_q > D2_MAX) ? D2_MAX[D2W-1:0] : acc_q[D2W-1:0];
	assign last_pt   = ((i_q + CNTW'(1)) == count_q);
	assign outside   = (acc_sat > D2W'(rr_q));
	assign sel       = (step_q == 2'd3) ? 2'd0 : step_q;
	assign mv_k      = step_q - 2'd1;
	assign rem_t     = {sq_rem_q[RMW-3:0], sq_n_q[D2W-1 -: 2]};
	assign trial     = {sq_root_q, 2'b01};
	assign root_ceil = SQW'(sq_root_q) + SQW'(sq_rem_q != '0);
	assign half_t    = (SQW+1)'(root_ceil) + (SQW+1)'(1);
	assign grow_t    = (SQW+1)'(r_q) + (SQW+1)'(d_q) + (SQW+1)'(1);
	assign rem2      = {dv_rem_q, 1'b0};
	assign den       = (SQW+2)'({d_q, 1'b0});

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mag_d[c] = diff_q[c][CB] ? (CB+1)'(-diff_q[c]) : diff_q[c];
		end
	end

	// move along one axis: sign of the old difference picks the direction
	always_comb begin
		if (diff_q[mv_k][CB]) begin
			c_new = {center_q[mv_k][CB-1], center_q[mv_k]} - prod_q[FB +: CB+1];
		end else begin
			c_new = {center_q[mv_k][CB-1], center_q[mv_k]} + prod_q[FB +: CB+1];
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			rbs_pkg::B_IDLE: begin
				if (!q_empty && q_ctl.last) state_n = rbs_pkg::B_AXDIFF;
			end
			rbs_pkg::B_AXDIFF: state_n = rbs_pkg::B_SUM;
			rbs_pkg::B_SUM: begin
				if (step_q == 2'd3) state_n = grow_q ? rbs_pkg::B_PTCMP : rbs_pkg::B_AXCMP;
			end
			rbs_pkg::B_AXCMP: begin
				state_n = (ax_q == 2'd2) ? rbs_pkg::B_INIT : rbs_pkg::B_AXDIFF;
			end
			rbs_pkg::B_INIT: state_n = rbs_pkg::B_SQRT;
			rbs_pkg::B_SQRT: begin
				if (sq_cnt_q == SQC'(SQH - 1)) state_n = rbs_pkg::B_SQDONE;
			end
			rbs_pkg::B_SQDONE: state_n = grow_q ? rbs_pkg::B_DIV : rbs_pkg::B_RR1;
			rbs_pkg::B_RR1:    state_n = rbs_pkg::B_RR2;
			rbs_pkg::B_RR2: begin
				state_n = (i_q == count_q) ? rbs_pkg::B_OUT : rbs_pkg::B_RD;
			end
			rbs_pkg::B_RD:     state_n = rbs_pkg::B_PTDIFF;
			rbs_pkg::B_PTDIFF: state_n = rbs_pkg::B_SUM;
			rbs_pkg::B_PTCMP: begin
				if (outside)      state_n = rbs_pkg::B_SQRT;
				else if (last_pt) state_n = rbs_pkg::B_OUT;
				else              state_n = rbs_pkg::B_RD;
			end
			rbs_pkg::B_DIV: begin
				if (dv_cnt_q == DVC'(FB - 1)) state_n = rbs_pkg::B_MOVE;
			end
			rbs_pkg::B_MOVE: begin
				if (step_q == 2'd3) state_n = rbs_pkg::B_RUPD;
			end
			rbs_pkg::B_RUPD: state_n = rbs_pkg::B_RR1;
			rbs_pkg::B_OUT: begin
				if (!out_valid_q) state_n = rbs_pkg::B_IDLE;
			end
			default: state_n = rbs_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == rbs_pkg::B_IDLE) && !q_empty;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			rbs_pkg::B_SUM: begin
				mul_a = mag_d[sel];
				mul_b = MBW'(mag_d[sel]);
			end
			rbs_pkg::B_MOVE: begin
				mul_a = mag_d[sel];
				mul_b = MBW'(f_q);
			end
			rbs_pkg::B_RR1: begin
				mul_a = (CB+1)'(r_q);
				mul_b = MBW'(r_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rbs_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == rbs_pkg::B_OUT && !out_valid_q) out_valid_q <= 1'b1;
			else if (pop && out_valid_q)                   out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_ctl.store) mem[q_idx] <= q_data[3*CB-1:0];
		if (state_q == rbs_pkg::B_RD) rdata_q <= mem[i_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a * mul_b);
		unique case (state_q)
			rbs_pkg::B_IDLE: begin
				if (q_pop && q_ctl.last) begin
					for (int a = 0; a < 3; a++) begin
						for (int c = 0; c < 3; c++) begin
							minp_q[a][c] <= q_data[(3+3*a+c)*CB +: CB];
							maxp_q[a][c] <= q_data[(12+3*a+c)*CB +: CB];
						end
					end
					count_q <= q_ctl.store ? CNTW'(q_idx) + CNTW'(1) : CNTW'(MAX_POINTS);
					drop_q  <= q_ctl.drop;
					i_q     <= '0;
					ax_q    <= 2'd0;
					bax_q   <= 2'd0;
					best_q  <= '0;
					grow_q  <= 1'b0;
				end
			end
			rbs_pkg::B_AXDIFF: begin
				for (int c = 0; c < 3; c++) begin
					diff_q[c] <= {maxp_q[ax_q][c][CB-1], maxp_q[ax_q][c]}
						- {minp_q[ax_q][c][CB-1], minp_q[ax_q][c]};
				end
				acc_q  <= '0;
				step_q <= 2'd0;
			end
			rbs_pkg::B_SUM: begin
				if (step_q != 2'd0) acc_q <= acc_q + ACCW'(prod_q[2*CB+1:0]);
				step_q <= step_q + 2'd1;
			end
			rbs_pkg::B_AXCMP: begin
				if (acc_sat > best_q) begin
					best_q <= acc_sat;
					bax_q  <= ax_q;
				end
				ax_q <= ax_q + 2'd1;
			end
			rbs_pkg::B_INIT: begin
				// floor of the pair midpoint
				for (int c = 0; c < 3; c++) begin
					center_q[c] <= CB'(({minp_q[bax_q][c][CB-1], minp_q[bax_q][c]}
						+ {maxp_q[bax_q][c][CB-1], maxp_q[bax_q][c]}) >>> 1);
				end
				sq_n_q    <= best_q;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				sq_cnt_q  <= '0;
			end
			rbs_pkg::B_SQRT: begin
				// two radicand bits per cycle
				if (rem_t >= trial) begin
					sq_rem_q  <= rem_t - trial;
					sq_root_q <= {sq_root_q[SQH-2:0], 1'b1};
				end else begin
					sq_rem_q  <= rem_t;
					sq_root_q <= {sq_root_q[SQH-2:0], 1'b0};
				end
				sq_n_q   <= sq_n_q << 2;
				sq_cnt_q <= sq_cnt_q + SQC'(1);
			end
			rbs_pkg::B_SQDONE: begin
				if (grow_q) begin
					d_q      <= root_ceil;
					dv_rem_q <= (SQW+1)'(root_ceil - SQW'(r_q));
					dv_cnt_q <= '0;
					f_q      <= '0;
				end else begin
					r_q <= (half_t[SQW:1] > SQW'(R_MAX)) ? R_MAX : half_t[CB:1];
				end
			end
			rbs_pkg::B_RR2: begin
				rr_q   <= prod_q[2*CB-1:0];
				grow_q <= 1'b1;
			end
			rbs_pkg::B_PTDIFF: begin
				for (int c = 0; c < 3; c++) begin
					diff_q[c] <= {rdata_q[c*CB+CB-1], rdata_q[c*CB +: CB]}
						- {center_q[c][CB-1], center_q[c]};
				end
				acc_q  <= '0;
				step_q <= 2'd0;
			end
			rbs_pkg::B_PTCMP: begin
				if (outside) begin
					sq_n_q    <= acc_sat;
					sq_rem_q  <= '0;
					sq_root_q <= '0;
					sq_cnt_q  <= '0;
				end else begin
					i_q <= i_q + CNTW'(1);
				end
			end
			rbs_pkg::B_DIV: begin
				// one quotient bit of (d - r) * 2^30 / (2d) per cycle
				if (rem2 >= den) begin
					dv_rem_q <= (SQW+1)'(rem2 - den);
					f_q      <= {f_q[FB-2:0], 1'b1};
				end else begin
					dv_rem_q <= rem2[SQW:0];
					f_q      <= {f_q[FB-2:0], 1'b0};
				end
				dv_cnt_q <= dv_cnt_q + DVC'(1);
				step_q   <= 2'd0;
			end
			rbs_pkg::B_MOVE: begin
				if (step_q != 2'd0) center_q[mv_k] <= c_new[CB-1:0];
				step_q <= step_q + 2'd1;
			end
			rbs_pkg::B_RUPD: begin
				r_q <= (grow_t[SQW:1] > SQW'(R_MAX)) ? R_MAX : grow_t[CB:1];
				i_q <= i_q + CNTW'(1);
			end
			rbs_pkg::B_OUT: begin
				if (!out_valid_q) begin
					out_center_q <= center_q;
					out_radius_q <= r_q;
					out_drop_q   <= drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign empty      = ~out_valid_q;
	assign center_x   = out_center_q[0];
	assign center_y   = out_center_q[1];
	assign center_z   = out_center_q[2];
	assign radius     = out_radius_q;
	assign overflowed = out_drop_q;
endmodule
`default_nettype wire

>>> src/bounding_sphere_ritter.sv
// ----------------------------------------------------------------------------
// bounding_sphere_ritter
// approximate bounding sphere of a point set, one result per closed set
// ----------------------------------------------------------------------------
// Points are taken one per cycle while there is room into a two-entry queue
// ahead of the solver, which writes them into the point store; the front keeps
// the extreme point of each axis as they arrive. When a point marked last
// reaches the solver it works on that set alone: it picks the start sphere,
// with a square root of R = COORD_BITS + 2 root steps (18 for 16-bit
// coordinates), then checks each stored point against the sphere and grows
// it for each point that lies outside. The solver is built around the
// single shared multiplier, the two-bit-per-cycle square root and the
// one-bit-per-cycle divide. While the solver is busy, push stalls once the
// queue is full; one finished result can wait on the output while the next
// set loads.
`default_nettype none
`include "bounding_sphere_ritter_defines.svh"
module bounding_sphere_ritter #(
	parameter int MAX_POINTS = rbs_pkg::RBS_MAX_POINTS,
	parameter int COORD_BITS = rbs_pkg::RBS_COORD_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic signed [COORD_BITS-1:0] x,
	input  wire logic signed [COORD_BITS-1:0] y,
	input  wire logic signed [COORD_BITS-1:0] z,
	input  wire logic                         last,
	output logic                              empty,
	input  wire logic                         pop,
	output logic signed [COORD_BITS-1:0]      center_x,
	output logic signed [COORD_BITS-1:0]      center_y,
	output logic signed [COORD_BITS-1:0]      center_z,
	output logic [COORD_BITS-1:0]             radius,
	output logic                              overflowed
);
	localparam int DW = 21*COORD_BITS + $clog2(MAX_POINTS);
	localparam int CW = $bits(rbs_pkg::rbs_ctl_t);

	rbs_pkg::rbs_ctl_t  f_ctl;
	rbs_pkg::rbs_ctl_t  q_ctl;
	logic [DW-1:0]      f_data;
	logic [DW-1:0]      q_data;
	logic [DW+CW-1:0]   q_rdata;
	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;

	assign q_push = push & ~q_full;
	assign full   = q_full;
	assign q_ctl  = q_rdata[DW +: CW];
	assign q_data = q_rdata[DW-1:0];

	rbs_front #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(q_push),
		.x(x),
		.y(y),
		.z(z),
		.last(last),
		.ctl(f_ctl),
		.data(f_data)
	);

	rbs_queue #(
		.W(DW + CW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata({f_ctl, f_data}),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	rbs_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_ctl(q_ctl),
		.q_data(q_data),
		.pop(pop),
		.empty(empty),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.radius(radius),
		.overflowed(overflowed)
	);

	`RBS_ASSERT_IMP(a_pop_has_entry, q_pop, !q_empty)
	`RBS_ASSERT_NXT(a_result_drains, pop && !empty, empty)
	`RBS_ASSERT_NXT(a_pop_frees_slot, q_pop && !q_push, !q_full)
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ritter bounding sphere block
// ----------------------------------------------------------------------------
// Point sets are pushed with random gaps and random output stalls. A local
// fixed-point model keeps the point store and the per-axis extremes, and
// solves each closed set. Every popped sphere is compared field by field with
// the oldest predicted one.
module tb;
	localparam int NPTS = rbs_pkg::RBS_MAX_POINTS;
	localparam int CB   = rbs_pkg::RBS_COORD_BITS;
	localparam int FB   = rbs_pkg::RBS_FRAC_BITS;

	typedef struct {
		logic signed [CB-1:0] cx;
		logic signed [CB-1:0] cy;
		logic signed [CB-1:0] cz;
		logic [CB-1:0]        rad;
		logic                 ovf;
	} sphere_t;

	logic clk, arst_n, push, full, last, empty, pop, overflowed;
	logic signed [CB-1:0] x, y, z, center_x, center_y, center_z;
	logic [CB-1:0] radius;

	bounding_sphere_ritter dut (.*);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// model state
	longint pt [NPTS][3];
	int     pt_cnt;
	int     lo_idx [3];
	int     hi_idx [3];
	bit     dropped;
	sphere_t spheres_due [$];

	int errors, n_points, n_spheres, n_ovf_sets, rx_hold, tx_gap_max;

	function automatic longint unsigned csqrt(longint unsigned n);
		longint unsigned r, t;
		r = 0;
		for (int b = 24; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n) r = t;
		end
		if (r * r < n) r++;
		return r;
	endfunction

	function automatic longint unsigned sqd(longint a0, longint a1, longint a2,
			longint b0, longint b1, longint b2);
		return (a0 - b0) * (a0 - b0) + (a1 - b1) * (a1 - b1) + (a2 - b2) * (a2 - b2);
	endfunction

	function automatic longint clampc(longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (CB - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic sphere_t solve_set();
		longint unsigned best, dd, r, d2, d, f, dl, lim;
		longint c [3];
		longint diff, magd;
		int ax;
		sphere_t s;
		best = 0;
		ax = 0;
		lim = (64'd1 << CB) - 1;
		for (int k = 0; k < 3; k++) begin
			dd = sqd(pt[lo_idx[k]][0], pt[lo_idx[k]][1], pt[lo_idx[k]][2],
				pt[hi_idx[k]][0], pt[hi_idx[k]][1], pt[hi_idx[k]][2]);
			if (dd > best) begin
				best = dd;
				ax = k;
			end
		end
		for (int k = 0; k < 3; k++)
			c[k] = clampc((pt[lo_idx[ax]][k] + pt[hi_idx[ax]][k]) >>> 1);
		r = (csqrt(best) + 1) >> 1;
		if (r > lim) r = lim;
		for (int i = 0; i < pt_cnt; i++) begin
			d2 = sqd(pt[i][0], pt[i][1], pt[i][2], c[0], c[1], c[2]);
			if (d2 > r * r) begin
				d = csqrt(d2);
				f = ((d - r) << FB) / (2 * d);
				for (int k = 0; k < 3; k++) begin
					diff = pt[i][k] - c[k];
					magd = diff < 0 ? -diff : diff;
					dl = (longint'(magd) * f) >> FB;
					c[k] = clampc(diff < 0 ? c[k] - longint'(dl) : c[k] + longint'(dl));
				end
				r = (r + d + 1) >> 1;
				if (r > lim) r = lim;
			end
		end
		s.cx = c[0][CB-1:0];
		s.cy = c[1][CB-1:0];
		s.cz = c[2][CB-1:0];
		s.rad = r[CB-1:0];
		s.ovf = dropped;
		return s;
	endfunction

	// model update for one accepted point
	task automatic model_point(logic signed [CB-1:0] px, py, pz, logic pl);
		if (pt_cnt < NPTS) begin
			pt[pt_cnt][0] = px;
			pt[pt_cnt][1] = py;
			pt[pt_cnt][2] = pz;
			for (int k = 0; k < 3; k++) begin
				if (pt[pt_cnt][k] < pt[lo_idx[k]][k]) lo_idx[k] = pt_cnt;
				if (pt[pt_cnt][k] > pt[hi_idx[k]][k]) hi_idx[k] = pt_cnt;
			end
			pt_cnt++;
		end else begin
			dropped = 1'b1;
		end
		n_points++;
		if (pl) begin
			spheres_due.push_back(solve_set());
			n_spheres++;
			if (dropped) n_ovf_sets++;
			pt_cnt = 0;
			dropped = 1'b0;
			lo_idx = '{0, 0, 0};
			hi_idx = '{0, 0, 0};
		end
	endtask

	task automatic send_point(logic signed [CB-1:0] px, py, pz, logic pl);
		int gap;
		gap = $urandom_range(tx_gap_max, 0);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		x <= px;
		y <= py;
		z <= pz;
		last <= pl;
		push <= 1'b1;
		do @(posedge clk); while (full);
		model_point(px, py, pz, pl);
	endtask

	// sender pauses until every predicted sphere has been popped
	task automatic drain();
		push <= 1'b0;
		while (spheres_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic signed [CB-1:0] rnd_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return $signed(CB'($urandom_range(200, 0))) - 100;
			2: return $urandom_range(1, 0) ? 16'sh7fff : 16'sh8000;
			default: return $signed(CB'($urandom_range(4000, 0))) - 2000;
		endcase
	endfunction

	task automatic send_set(int n, int mode);
		for (int i = 0; i < n; i++)
			send_point(rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), i == n - 1);
	endtask

	task automatic report(string what, logic [CB-1:0] got, logic [CB-1:0] want);
		$display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int n;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
			end else begin
				n = $urandom_range(3, 0) == 0 ? 0 : $urandom_range(11, 0);
			end
			if (n > 0) begin
				pop <= 1'b0;
				repeat (n) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	// check each transfer against the oldest prediction
	always @(posedge clk) begin
		sphere_t e;
		if (arst_n && pop && !empty) begin
			if (spheres_due.size() == 0) begin
				$display("tb: unexpected sphere at %0t", $time);
				errors++;
			end else begin
				e = spheres_due.pop_front();
				if (center_x !== e.cx) report("center_x", center_x, e.cx);
				if (center_y !== e.cy) report("center_y", center_y, e.cy);
				if (center_z !== e.cz) report("center_z", center_z, e.cz);
				if (radius !== e.rad) report("radius", radius, e.rad);
				if (overflowed !== e.ovf) report("overflowed", overflowed, e.ovf);
			end
		end
	end

	task automatic test_directed();
		send_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b1);
		send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		// identical points, every axis tied
		send_point(16'sh0123, -16'sh0456, 16'sh0789, 1'b0);
		send_point(16'sh0123, -16'sh0456, 16'sh0789, 1'b1);
		// z spread widest, x and y tied
		send_point(-16'sd10, 16'sd10, 16'sh8000, 1'b0);
		send_point(16'sd10, -16'sd10, 16'sh7fff, 1'b1);
		// the corner pair sets the start sphere; the other points lie inside it
		send_point(-16'sd1000, 16'sd0, 16'sd0, 1'b0);
		send_point(16'sd1000, 16'sd0, 16'sd0, 1'b0);
		send_point(16'sd0, 16'sd5000, 16'sd0, 1'b0);
		send_point(16'sd0, -16'sd7000, 16'sd3000, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
		drain();
	endtask

	task automatic test_store_full();
		send_set(NPTS, 3);
		send_set(NPTS + 1, 0);
		send_set(NPTS + 6, 1);
		drain();
	endtask

	task automatic test_backpressure();
		rx_hold = 400;
		tx_gap_max = 0;
		for (int i = 0; i < 8; i++) send_set($urandom_range(5, 1), 0);
		tx_gap_max = 11;
		drain();
	endtask

	task automatic test_random();
		int n;
		while (n_points < 1400) begin
			case ($urandom_range(19, 0))
				0:       n = $urandom_range(NPTS + 4, NPTS - 2);
				1, 2:    n = $urandom_range(40, 13);
				default: n = $urandom_range(12, 1);
			endcase
			// occasional runs with no sender gaps
			tx_gap_max = $urandom_range(4, 0) == 0 ? 0 : 11;
			send_set(n, $urandom_range(3, 0));
			if ($urandom_range(15, 0) == 0) drain();
		end
		tx_gap_max = 11;
		drain();
	endtask

	initial begin
		#4000000;
		$display("tb: FAIL");
		$finish;
	end

	initial begin
		errors = 0;
		n_points = 0;
		n_spheres = 0;
		n_ovf_sets = 0;
		rx_hold = 0;
		tx_gap_max = 11;
		pt_cnt = 0;
		dropped = 1'b0;
		lo_idx = '{0, 0, 0};
		hi_idx = '{0, 0, 0};
		arst_n = 1'b0;
		push = 1'b0;
		x = '0;
		y = '0;
		z = '0;
		last = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_store_full();
		test_backpressure();
		test_random();
		repeat (50) @(posedge clk);
		$display("tb: %0d points in %0d sets, %0d sets with dropped points",
			n_points, n_spheres, n_ovf_sets);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: %0d mismatches", errors);
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule
